@@ design/turn_rate_profile_macros.svh @@
// -----------------------------------------------------------------------------
// turn_rate_profile assertion macros
// Concurrent assertion wrappers used by the checker file.
// -----------------------------------------------------------------------------
`ifndef TURN_RATE_PROFILE_MACROS_SVH
`define TURN_RATE_PROFILE_MACROS_SVH

// Property checked while out of reset
`define TRP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked at every edge, reset included
`define TRP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ design/trp_pkg.sv @@
// -----------------------------------------------------------------------------
// trp_pkg
// Widths, reset values, register map and shared types of the turn rate block.
// -----------------------------------------------------------------------------
package trp_pkg;

    // field widths
    localparam int RATE_W     = 21;   // max_rate, min_rate
    localparam int ANG_W      = 20;   // slowdown_angle, tolerance
    localparam int HEAD_W     = 25;   // heading, signed
    localparam int TURN_W     = 21;   // turn_angle, signed
    localparam int TGT_W      = 26;   // target heading, signed
    localparam int REM_W      = 27;   // remaining angle, signed
    localparam int MAG_W      = 26;   // |remaining|
    localparam int YAW_W      = 22;   // yaw_rate, signed

    // ramp arithmetic
    localparam int PROD_W     = RATE_W + ANG_W;  // |max - min| * (|rem| - tol)
    localparam int QUO_W      = RATE_W;          // quotient never exceeds |max - min|
    localparam int DIV_STEPS  = PROD_W;          // one quotient bit per cycle
    localparam int CNT_W      = $clog2(DIV_STEPS + 1);

    // stream and bus widths
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 56;
    localparam int APB_AW      = 4;
    localparam int APB_DW      = 32;

    // reset values of the registers
    localparam logic [RATE_W-1:0] MAX_RATE_RST = RATE_W'(90000);
    localparam logic [RATE_W-1:0] MIN_RATE_RST = RATE_W'(10000);
    localparam logic [ANG_W-1:0]  SLOW_RST     = ANG_W'(30000);
    localparam logic [ANG_W-1:0]  TOL_RST      = ANG_W'(1000);

    // register indexes (byte address 4*index)
    localparam logic [1:0] REG_MAX_RATE = 2'd0;
    localparam logic [1:0] REG_MIN_RATE = 2'd1;
    localparam logic [1:0] REG_SLOWDOWN = 2'd2;
    localparam logic [1:0] REG_TOL      = 2'd3;

    // operation codes
    localparam logic OP_START  = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // divider status
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

@@ design/trp_div.sv @@
// -----------------------------------------------------------------------------
// trp_div
// Restoring unsigned divider, one quotient bit per cycle.
// -----------------------------------------------------------------------------
module trp_div import trp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_dividend,
    input  logic [ANG_W-1:0]  i_divisor,
    output logic [QUO_W-1:0]  o_quotient,
    output t_div_sts          o_sts
);

    logic [PROD_W-1:0] r_quo;     // dividend shifts out, quotient shifts in
    logic [ANG_W-1:0]  r_rem;
    logic [ANG_W-1:0]  r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [ANG_W:0]    w_shift;
    logic [ANG_W:0]    w_diff;
    logic              w_ge;

    // shift-compare-subtract step
    assign w_shift = {r_rem, r_quo[PROD_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_div});
    assign w_diff  = w_shift - {1'b0, r_div};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[PROD_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[ANG_W-1:0] : w_shift[ANG_W-1:0];
        end
    end

    assign o_quotient = r_quo[QUO_W-1:0];
    assign o_sts      = '{busy: r_busy, done: r_done};

endmodule

@@ design/turn_rate_profile.sv @@
// -----------------------------------------------------------------------------
// turn_rate_profile
// Yaw rate command for a relative turn with a linear slowdown ramp.
// -----------------------------------------------------------------------------
//  channel   dir  handshake               payload
//  s_axis    in   tvalid/tready           tdata: heading, turn_angle; tuser: operation
//  m_axis    out  tvalid/tready           tdata: yaw_rate, remaining; tuser: done_res
//  apb       in   psel/penable, pready=1  four 32-bit registers at 0x0..0xC
//
//  Start beats and updates without a ramp pass ST_ABS, ST_DECIDE and ST_OUT.
//  A ramp update also passes ST_MUL, ST_DSTART and ST_DIV, where it waits on
//  the 41-step bit-serial divider.
//  One item is in work at a time; tready is high only in the idle state.
//  The result register frees the core: a stalled result holds while the next
//  beat is accepted, and a finished item waits only if that register is full.
//  Reset is synchronous; it restores register defaults and marks no turn active.
// -----------------------------------------------------------------------------
module turn_rate_profile import trp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // [24:0] heading, [45:25] turn_angle
    input  logic                   i_s_axis_tuser,   // [0] operation
    // output stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // [21:0] yaw_rate, [48:22] remaining
    output logic                   o_m_axis_tuser,   // [0] done_res
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_AW-1:0]      paddr,
    input  logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ABS    = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_DSTART = 3'd4;
    localparam logic [2:0] ST_DIV    = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    // configuration registers
    logic [RATE_W-1:0] r_max_rate;
    logic [RATE_W-1:0] r_min_rate;
    logic [ANG_W-1:0]  r_slow;
    logic [ANG_W-1:0]  r_tol;

    // turn state
    logic [TGT_W-1:0]  r_target;
    logic              r_turn_done;

    // sequencer and working registers
    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic              r_op;
    logic [REM_W-1:0]  r_rem;
    logic [MAG_W-1:0]  r_mag;
    logic [ANG_W-1:0]  r_delta;
    logic [ANG_W-1:0]  r_span;
    logic [RATE_W-1:0] r_abs_diff;
    logic              r_diff_neg;
    logic [PROD_W-1:0] r_prod;
    logic [YAW_W-1:0]  r_rate;

    // output register
    logic                   r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data;
    logic                   r_m_user;

    // combinational helpers
    logic              w_s_fire;
    logic              w_cfg_wr;
    logic              w_out_load;
    logic [HEAD_W-1:0] w_head;
    logic [TURN_W-1:0] w_turn;
    logic [REM_W-1:0]  w_head_x;
    logic [REM_W-1:0]  w_abs;
    logic [MAG_W-1:0]  w_tol_x;
    logic [MAG_W-1:0]  w_slow_x;
    logic [MAG_W-1:0]  w_delta;
    logic [YAW_W-1:0]  w_diff;
    logic [YAW_W-1:0]  w_max_s;
    logic [YAW_W:0]    w_q_s;
    logic [YAW_W:0]    w_ramp;
    logic [YAW_W:0]    w_ramp_s;
    logic              w_div_start;
    logic [QUO_W-1:0]  w_quo;
    t_div_sts          w_div_sts;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_s_fire        = i_s_axis_tvalid & o_s_axis_tready;
    assign w_head          = i_s_axis_tdata[HEAD_W-1:0];
    assign w_turn          = i_s_axis_tdata[HEAD_W +: TURN_W];
    assign w_head_x        = {{(REM_W-HEAD_W){w_head[HEAD_W-1]}}, w_head};

    // APB register file
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_rate <= MAX_RATE_RST;
            r_min_rate <= MIN_RATE_RST;
            r_slow     <= SLOW_RST;
            r_tol      <= TOL_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_MAX_RATE: r_max_rate <= pwdata[RATE_W-1:0];
                REG_MIN_RATE: r_min_rate <= pwdata[RATE_W-1:0];
                REG_SLOWDOWN: r_slow     <= pwdata[ANG_W-1:0];
                REG_TOL:      r_tol      <= pwdata[ANG_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MAX_RATE: prdata = {{(APB_DW-RATE_W){1'b0}}, r_max_rate};
            REG_MIN_RATE: prdata = {{(APB_DW-RATE_W){1'b0}}, r_min_rate};
            REG_SLOWDOWN: prdata = {{(APB_DW-ANG_W){1'b0}}, r_slow};
            REG_TOL:      prdata = {{(APB_DW-ANG_W){1'b0}}, r_tol};
        endcase
    end

    // decision datapath
    assign w_abs    = r_rem[REM_W-1] ? (REM_W'(0) - r_rem) : r_rem;
    assign w_tol_x  = {{(MAG_W-ANG_W){1'b0}}, r_tol};
    assign w_slow_x = {{(MAG_W-ANG_W){1'b0}}, r_slow};
    assign w_delta  = r_mag - w_tol_x;
    assign w_diff   = {1'b0, r_max_rate} - {1'b0, r_min_rate};
    assign w_max_s  = r_rem[REM_W-1] ? (YAW_W'(0) - {1'b0, r_max_rate})
                                     : {1'b0, r_max_rate};

    // ramp result: min + signed quotient, then sign of remaining angle
    assign w_q_s    = r_diff_neg ? ((YAW_W+1)'(0) - {2'b00, w_quo}) : {2'b00, w_quo};
    assign w_ramp   = {2'b00, r_min_rate} + w_q_s;
    assign w_ramp_s = r_rem[REM_W-1] ? ((YAW_W+1)'(0) - w_ramp) : w_ramp;

    assign w_div_start = (r_state == ST_DSTART);
    assign w_out_load  = (r_state == ST_OUT) && (!r_m_valid || i_m_axis_tready);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (w_s_fire) n_state = ST_ABS;
            ST_ABS:    n_state = ST_DECIDE;
            ST_DECIDE: begin
                if (r_op == OP_UPDATE && !r_turn_done && r_mag > w_tol_x
                    && r_mag < w_slow_x && r_slow > r_tol) begin
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_MUL:    n_state = ST_DSTART;
            ST_DSTART: n_state = ST_DIV;
            ST_DIV:    if (w_div_sts.done) n_state = ST_OUT;
            ST_OUT:    if (w_out_load) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // turn state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= '0;
            r_turn_done <= 1'b1;
        end else if (w_s_fire && i_s_axis_tuser == OP_START) begin
            r_target    <= {w_head[HEAD_W-1], w_head}
                         + {{(TGT_W-TURN_W){w_turn[TURN_W-1]}}, w_turn};
            r_turn_done <= 1'b0;
        end else if (r_state == ST_DECIDE && r_op == OP_UPDATE && !r_turn_done
                     && r_mag <= w_tol_x) begin
            r_turn_done <= 1'b1;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (w_s_fire) begin
                    r_op <= i_s_axis_tuser;
                    if (i_s_axis_tuser == OP_START) begin
                        r_rem <= {{(REM_W-TURN_W){w_turn[TURN_W-1]}}, w_turn};
                    end else begin
                        r_rem <= {r_target[TGT_W-1], r_target} - w_head_x;
                    end
                end
            end
            ST_ABS: r_mag <= w_abs[MAG_W-1:0];
            ST_DECIDE: begin
                r_delta    <= w_delta[ANG_W-1:0];
                r_span     <= r_slow - r_tol;
                r_diff_neg <= w_diff[YAW_W-1];
                r_abs_diff <= w_diff[YAW_W-1] ? RATE_W'(YAW_W'(0) - w_diff)
                                              : w_diff[RATE_W-1:0];
                // rate 0 for start, idle turn or arrival; max rate outside the ramp
                if (r_op == OP_UPDATE && !r_turn_done && r_mag > w_tol_x) begin
                    r_rate <= w_max_s;
                end else begin
                    r_rate <= '0;
                end
            end
            ST_MUL: r_prod <= r_abs_diff * r_delta;
            ST_DIV: if (w_div_sts.done) r_rate <= w_ramp_s[YAW_W-1:0];
            default: ;
        endcase
    end

    // divider for the ramp quotient
    trp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_span),
        .o_quotient (w_quo),
        .o_sts      (w_div_sts)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_m_data <= {{(OUT_TDATA_W-REM_W-YAW_W){1'b0}}, r_rem, r_rate};
            r_m_user <= r_turn_done;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;

endmodule

@@ design/trp_checker.sv @@
// -----------------------------------------------------------------------------
// trp_checker
// Port-level checks of the turn rate block, bound to the top level.
// -----------------------------------------------------------------------------
`include "turn_rate_profile_macros.svh"

module trp_checker import trp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    input  logic                   o_s_axis_tready,
    input  logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                   o_m_axis_tuser
);

    // a stalled result beat keeps its payload
    `TRP_ASSERT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "result beat changed while stalled")

    // the core is busy right after it takes a beat
    `TRP_ASSERT(a_busy_after_accept, i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready, "input ready again right after accept")

    // a finished or inactive turn never commands a rate
    `TRP_ASSERT(a_done_zero_rate, o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata[YAW_W-1:0] == '0, "nonzero yaw rate with done flag set")

    // reset empties the result register
    `TRP_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_m_axis_tvalid, "result valid after reset")

endmodule

bind turn_rate_profile trp_checker u_trp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

@@ dv/turn_rate_profile_test.sv @@
// -----------------------------------------------------------------------------
// turn_rate_profile_test
// Self-checking bench for the turn rate block. An internal predictor tracks
// the stored target heading, the done flag and the four rate/angle
// registers, and it works out the yaw rate, the remaining angle and the done
// bit for every accepted input beat. Each output beat is checked against the
// oldest predicted result. Stimulus is a short directed set, then phases under
// different register settings with mostly well-formed turns (a start, then
// updates that sweep through the cruise, ramp and arrival zones) mixed with
// random noise beats. The input side sends in bursts and the output side
// stalls on its own pattern.
// -----------------------------------------------------------------------------
`timescale 1ns / 100ps

module turn_rate_profile_test;
    import trp_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HDG_MAX     = 16777215;
    localparam int TURN_MAX    = 720000;
    localparam int RATE_MAX    = 2000000;
    localparam int ANG_MAX     = 720000;
    localparam int PHASE_BEATS = 128;

    // one predicted output beat
    typedef struct packed {
        logic signed [YAW_W-1:0] yaw;
        logic signed [REM_W-1:0] rem;
        logic                    done;
    } rate_cmd_t;

    // predictor of the yaw command, plus the queue of results still due
    class yaw_rate_checker;
        logic [RATE_W-1:0]       max_rate;
        logic [RATE_W-1:0]       min_rate;
        logic [ANG_W-1:0]        slow_ang;
        logic [ANG_W-1:0]        tol_ang;
        logic signed [TGT_W-1:0] target_hdg;
        logic                    turn_done;
        rate_cmd_t               due_rates[$];
        int                      errors;

        function new();
            max_rate   = MAX_RATE_RST;
            min_rate   = MIN_RATE_RST;
            slow_ang   = SLOW_RST;
            tol_ang    = TOL_RST;
            target_hdg = '0;
            turn_done  = 1'b1;
            errors     = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [APB_DW-1:0] val);
            case (idx)
                REG_MAX_RATE: max_rate = val[RATE_W-1:0];
                REG_MIN_RATE: min_rate = val[RATE_W-1:0];
                REG_SLOWDOWN: slow_ang = val[ANG_W-1:0];
                REG_TOL:      tol_ang  = val[ANG_W-1:0];
                default: ;
            endcase
        endfunction

        // work out the result of one accepted input beat
        function void note_command(logic op, logic signed [HEAD_W-1:0] head,
                                   logic signed [TURN_W-1:0] turn);
            longint    hdg;
            longint    rem;
            longint    mag;
            longint    tol;
            longint    slow;
            longint    span;
            longint    rate;
            rate_cmd_t cmd;
            hdg  = head;
            rate = 0;
            if (op == OP_START) begin
                target_hdg = TGT_W'(hdg + longint'(turn));
                turn_done  = 1'b0;
            end
            rem = longint'(target_hdg) - hdg;
            if (op == OP_UPDATE && !turn_done) begin
                mag  = (rem < 0) ? -rem : rem;
                tol  = longint'(tol_ang);
                slow = longint'(slow_ang);
                if (mag <= tol) begin
                    turn_done = 1'b1;
                end else begin
                    span = slow - tol;
                    rate = longint'(max_rate);
                    // linear ramp inside the slowdown zone, quotient toward zero
                    if (mag < slow && span > 0)
                        rate = longint'(min_rate) +
                               ((longint'(max_rate) - longint'(min_rate)) * (mag - tol)) / span;
                    if (rem < 0)
                        rate = -rate;
                end
            end
            cmd.yaw  = YAW_W'(rate);
            cmd.rem  = REM_W'(rem);
            cmd.done = turn_done;
            due_rates.push_back(cmd);
        endfunction

        // compare one output beat with the oldest prediction
        function void check_rate(logic signed [YAW_W-1:0] yaw,
                                 logic signed [REM_W-1:0] rem, logic done);
            rate_cmd_t want;
            if (due_rates.size() == 0) begin
                errors++;
                $display("%0t: result with none due: yaw %0d rem %0d done %0b",
                         $time, yaw, rem, done);
                return;
            end
            want = due_rates.pop_front();
            if (yaw !== want.yaw) begin
                errors++;
                $display("%0t: yaw_rate expected %0d, got %0d", $time, want.yaw, yaw);
            end
            if (rem !== want.rem) begin
                errors++;
                $display("%0t: remaining expected %0d, got %0d", $time, want.rem, rem);
            end
            if (done !== want.done) begin
                errors++;
                $display("%0t: done_res expected %0b, got %0b", $time, want.done, done);
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;   // [24:0] heading, [45:25] turn_angle
    logic                   i_s_axis_tuser;   // [0] operation
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;   // [21:0] yaw_rate, [48:22] remaining
    logic                   o_m_axis_tuser;   // [0] done_res
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_AW-1:0]      paddr;
    logic [APB_DW-1:0]      pwdata;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;

    yaw_rate_checker rate_chk = new();

    int cycle_cnt  = 0;
    int beats_sent = 0;
    int burst_left = 0;
    int stall_left = 0;
    int rx_mode    = 0;
    int tgt_hdg    = 0;

    turn_rate_profile dut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("turn_rate_profile_test: done, errors");
            $finish;
        end
    end

    // beat monitor on both streams
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                rate_chk.note_command(i_s_axis_tuser, i_s_axis_tdata[HEAD_W-1:0],
                                      i_s_axis_tdata[HEAD_W+TURN_W-1:HEAD_W]);
            if (o_m_axis_tvalid && i_m_axis_tready)
                rate_chk.check_rate(o_m_axis_tdata[YAW_W-1:0],
                                    o_m_axis_tdata[YAW_W+REM_W-1:YAW_W], o_m_axis_tuser);
        end
    end

    // receiver stalls: free running, short frequent, or rare long stalls
    always @(negedge i_clk) begin
        if (cycle_cnt % 300 == 0)
            rx_mode = $urandom_range(0, 2);
        if (stall_left > 0) begin
            i_m_axis_tready = 1'b0;
            stall_left--;
        end else begin
            i_m_axis_tready = 1'b1;
            case (rx_mode)
                1: if ($urandom_range(0, 1) == 0) stall_left = $urandom_range(1, 3);
                2: if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(5, 40);
                default: ;
            endcase
        end
    end

    // one input beat; called and returns at a falling edge
    task automatic send_beat(logic op, int head, int turn);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = IN_TDATA_W'({TURN_W'(turn), HEAD_W'(head)});
        i_s_axis_tuser  = op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
        beats_sent++;
    endtask

    task automatic begin_turn(int head, int turn);
        tgt_hdg = head + turn;
        send_beat(OP_START, head, turn);
    endtask

    // update with the heading that leaves the given remaining angle
    task automatic update_at(int rem);
        int head;
        head = tgt_hdg - rem;
        if (head > HDG_MAX) head = HDG_MAX;
        if (head < -HDG_MAX) head = -HDG_MAX;
        send_beat(OP_UPDATE, head, int'($urandom_range(0, 2 * TURN_MAX)) - TURN_MAX);
    endtask

    // remaining angle aimed at the cruise, ramp, arrival zones or their edges
    function automatic int pick_rem();
        int tol;
        int slow;
        int mag;
        int sel;
        tol  = rate_chk.tol_ang;
        slow = rate_chk.slow_ang;
        sel  = $urandom_range(0, 9);
        mag  = $urandom_range(slow, slow + 900000);
        if (sel >= 3 && sel <= 5 && slow > tol + 1)
            mag = $urandom_range(tol + 1, slow - 1);
        else if (sel == 6)
            mag = $urandom_range(0, tol);
        else if (sel == 7) begin
            case ($urandom_range(0, 3))
                0: mag = tol;
                1: mag = tol + 1;
                2: mag = (slow > 0) ? slow - 1 : 0;
                default: mag = slow;
            endcase
        end else if (sel >= 8)
            mag = $urandom_range(0, 3000000);
        return ($urandom_range(0, 1) == 0) ? mag : -mag;
    endfunction

    // start, a run of updates, and often the arrival and beats after it
    task automatic run_turn();
        int n;
        begin_turn(int'($urandom_range(0, 32000000)) - 16000000,
                   int'($urandom_range(0, 2 * TURN_MAX)) - TURN_MAX);
        n = $urandom_range(2, 10);
        repeat (n) update_at(pick_rem());
        if ($urandom_range(0, 1) == 0) begin
            update_at(int'($urandom_range(0, rate_chk.tol_ang)));
            repeat ($urandom_range(0, 2)) update_at(pick_rem());
        end
    endtask

    task automatic noise_beat();
        send_beat(logic'($urandom_range(0, 1)),
                  int'($urandom_range(0, 2 * HDG_MAX)) - HDG_MAX,
                  int'($urandom_range(0, 2 * TURN_MAX)) - TURN_MAX);
    endtask

    task automatic wait_drain();
        i_s_axis_tvalid = 1'b0;
        while (rate_chk.due_rates.size() != 0) @(negedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic write_reg(logic [1:0] idx, int unsigned val);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        rate_chk.set_reg(idx, val);
    endtask

    task automatic write_cfg(int unsigned max_r, int unsigned min_r,
                             int unsigned slow, int unsigned tol);
        write_reg(REG_MAX_RATE, max_r);
        write_reg(REG_MIN_RATE, min_r);
        write_reg(REG_SLOWDOWN, slow);
        write_reg(REG_TOL, tol);
    endtask

    task automatic run_phase();
        int stop_at;
        stop_at = beats_sent + PHASE_BEATS;
        while (beats_sent < stop_at) begin
            if ($urandom_range(0, 4) != 0)
                run_turn();
            else
                noise_beat();
        end
        wait_drain();
    endtask

    // main sequence
    initial begin
        int slow;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: no active turn, field extremes, ramp edges, arrival
        send_beat(OP_UPDATE, 0, 0);
        send_beat(OP_UPDATE, HDG_MAX, -TURN_MAX);
        begin_turn(-HDG_MAX, -TURN_MAX);
        send_beat(OP_UPDATE, HDG_MAX, TURN_MAX);
        begin_turn(HDG_MAX, TURN_MAX);
        send_beat(OP_UPDATE, -HDG_MAX, 0);
        begin_turn(5000000, 300000);
        update_at(20000);
        update_at(-20000);
        update_at(30000);
        update_at(29999);
        update_at(-29999);
        update_at(1001);
        update_at(-1001);
        update_at(1000);
        update_at(50000);
        begin_turn(0, 0);
        update_at(0);
        begin_turn(-1, 1);
        update_at(-1);
        wait_drain();

        // register settings: defaults, extremes, inverted ramp, no ramp, random
        run_phase();
        write_cfg(RATE_MAX, 0, ANG_MAX, 0);
        run_phase();
        write_cfg(0, RATE_MAX, ANG_MAX, 1);
        run_phase();
        write_cfg(50000, 5000, 0, ANG_MAX);
        run_phase();
        write_cfg(123456, 7890, 4000, 4000);
        run_phase();
        repeat (2) begin
            slow = $urandom_range(0, ANG_MAX);
            write_cfg($urandom_range(0, RATE_MAX), $urandom_range(0, RATE_MAX),
                      slow, $urandom_range(0, slow / 8));
            run_phase();
        end
        write_cfg(90000, 10000, 30000, 1000);
        run_phase();

        wait_drain();
        repeat (60) @(posedge i_clk);
        if (rate_chk.errors == 0)
            $display("turn_rate_profile_test: done, clean");
        else
            $display("turn_rate_profile_test: done, errors");
        $finish;
    end

endmodule
